FILE: rtl/sge_pkg.sv
// Shared constants and types for the Sobel gradient energy block.
package sge_pkg;

    localparam int unsigned MAX_COLS     = 128;
    localparam int unsigned MAX_ROWS     = 128;
    localparam int unsigned MIN_DIM      = 3;
    localparam int unsigned PIX_W        = 8;
    localparam int unsigned CFG_W        = 8;
    localparam int unsigned ROW_W        = $clog2(MAX_ROWS);
    localparam int unsigned MAG_W        = 15;
    localparam int unsigned TDATA_IN_W   = 8;
    localparam int unsigned TDATA_OUT_W  = 16;
    localparam int unsigned GRAD_W       = 11;
    localparam int unsigned ENERGY_SHIFT = 6;
    localparam int unsigned LINE_W       = 2 * PIX_W;
    localparam int unsigned CFG_RESET    = 128;

    typedef enum logic [0:0] {
        REG_IMAGE_COLS = 1'b0,
        REG_IMAGE_ROWS = 1'b1
    } cfg_index_t;

    // Per-item tags carried along the pipeline
    typedef struct packed {
        logic emit;
        logic last;
    } tag_t;

endpackage

FILE: rtl/sge_line_mem.sv
// Dual line store: one synchronous memory holding the two previous rows per column.
module sge_line_mem #(
    parameter int unsigned DEPTH  = sge_pkg::MAX_COLS,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [sge_pkg::LINE_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [sge_pkg::LINE_W-1:0]  rd_data
);

    logic [sge_pkg::LINE_W-1:0] mem [DEPTH];
    logic [sge_pkg::LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sge_gradient.sv
// 3x3 window shift registers and Sobel x/y gradient stage.
module sge_gradient (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic [sge_pkg::PIX_W-1:0]         top,
    input  logic [sge_pkg::PIX_W-1:0]         mid,
    input  logic [sge_pkg::PIX_W-1:0]         bot,
    output logic signed [sge_pkg::GRAD_W-1:0] gx,
    output logic signed [sge_pkg::GRAD_W-1:0] gy
);

    localparam int unsigned GW = sge_pkg::GRAD_W;

    // win_reg[0..2]: column c-2 top/mid/bottom, win_reg[3..5]: column c-1
    logic [sge_pkg::PIX_W-1:0] win_reg [6];
    logic signed [GW-1:0]      gx_reg;
    logic signed [GW-1:0]      gy_reg;
    logic [GW-1:0]             right_sum, left_sum, low_sum, high_sum;

    always_comb begin
        right_sum = GW'(top) + (GW'(mid) << 1) + GW'(bot);
        left_sum  = GW'(win_reg[0]) + (GW'(win_reg[1]) << 1) + GW'(win_reg[2]);
        low_sum   = GW'(win_reg[2]) + (GW'(win_reg[5]) << 1) + GW'(bot);
        high_sum  = GW'(win_reg[0]) + (GW'(win_reg[3]) << 1) + GW'(top);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (adv) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gx_reg <= $signed(right_sum - left_sum);
            gy_reg <= $signed(low_sum - high_sum);
        end
    end

    assign gx = gx_reg;
    assign gy = gy_reg;

endmodule

FILE: rtl/sge_energy.sv
// Squared-gradient sum, scaled, into the output register.
module sge_energy (
    input  logic                              aclk,
    input  logic                              load,
    input  logic signed [sge_pkg::GRAD_W-1:0] gx,
    input  logic signed [sge_pkg::GRAD_W-1:0] gy,
    output logic [sge_pkg::MAG_W-1:0]         magnitude
);

    localparam int unsigned SW = 2 * sge_pkg::GRAD_W;

    logic signed [SW-1:0]       sq_x, sq_y, sq_sum;
    logic [sge_pkg::MAG_W-1:0]  mag_reg;

    always_comb begin
        sq_x   = SW'(gx) * SW'(gx);
        sq_y   = SW'(gy) * SW'(gy);
        sq_sum = sq_x + sq_y;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mag_reg <= sq_sum[sge_pkg::MAG_W+sge_pkg::ENERGY_SHIFT-1:sge_pkg::ENERGY_SHIFT];
        end
    end

    assign magnitude = mag_reg;

endmodule

FILE: rtl/sobel_gradient_energy_top.sv
// Top level of the 3x3 Sobel gradient energy block.
//
//  Channel  | Ports                         | Word contents (low bit up)
//  ---------+-------------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata     | tdata: pixel[7:0]
//           | s_tuser                       | tuser: frame_start
//  result   | m_tvalid m_tready m_tdata     | tdata: magnitude[14:0], zero pad
//           | m_tlast                       | tlast: frame_last
//  config   | cfg_wr_en cfg_wr_index        | index 0: image_cols, 1: image_rows
//           | cfg_wr_data                   |
//
// Takes one pixel word per clock while s_tready is high. A word flows through three
// registers: accept and line store read, window and gradients, energy into the output
// register. The single line store port pair (one read at accept, one write-back when the
// word leaves the accept register) sets the one-word-per-cycle rate.
// Reset is synchronous; the line store is not cleared. A stall on m_tready holds the
// output register; stages behind it fill up, and s_tready drops only once all are full.
module sobel_gradient_energy_top #(
    parameter int unsigned MAX_COLS = sge_pkg::MAX_COLS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sge_pkg::TDATA_IN_W-1:0]     s_tdata,   // pixel
    input  logic                               s_tuser,   // frame_start
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sge_pkg::TDATA_OUT_W-1:0]    m_tdata,   // magnitude, zero
    output logic                               m_tlast,   // frame_last
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [0:0]                         cfg_wr_index,
    input  logic [sge_pkg::CFG_W-1:0]          cfg_wr_data
);

    localparam int unsigned COL_W = $clog2(MAX_COLS);
    localparam int unsigned CMP_W = ($clog2(MAX_COLS + 1) > sge_pkg::CFG_W) ?
                                    $clog2(MAX_COLS + 1) : sge_pkg::CFG_W;
    localparam int unsigned PW    = sge_pkg::PIX_W;
    localparam int unsigned ROW_W = sge_pkg::ROW_W;

    // Configuration registers
    logic [sge_pkg::CFG_W-1:0] cols_cfg_reg, rows_cfg_reg;
    logic [CMP_W-1:0]          cols_eff;
    logic [sge_pkg::CFG_W-1:0] rows_eff;

    // Raster position
    logic [COL_W-1:0] col_reg, col_next, cur_col;
    logic [ROW_W-1:0] row_reg, row_next, cur_row;
    logic [CMP_W-1:0]          col_plus;
    logic [sge_pkg::CFG_W-1:0] row_plus;
    logic             row_end, frame_end;
    sge_pkg::tag_t    in_tag;

    // Pipeline control
    logic             s1_valid_reg, s1_valid_next;
    logic             s2_valid_reg, s2_valid_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free, s2_free, s1_free;
    logic             in_fire, s1_fire, s2_fire;

    // Stage payloads
    logic [COL_W-1:0]          s1_addr_reg;
    logic [PW-1:0]             s1_pixel_reg;
    sge_pkg::tag_t             s1_tag_reg;
    logic                      s2_last_reg, m_last_reg;

    // Line store and write-back forwarding
    logic [sge_pkg::LINE_W-1:0] rd_word, line_word, wr_word;
    logic [sge_pkg::LINE_W-1:0] fwd_data_reg;
    logic                       fwd_hit_reg;
    logic [PW-1:0]              top_px, mid_px;

    logic signed [sge_pkg::GRAD_W-1:0] gx, gy;
    logic [sge_pkg::MAG_W-1:0]         magnitude;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= sge_pkg::CFG_W'(sge_pkg::CFG_RESET);
            rows_cfg_reg <= sge_pkg::CFG_W'(sge_pkg::CFG_RESET);
        end else if (cfg_wr_en) begin
            unique case (sge_pkg::cfg_index_t'(cfg_wr_index))
                sge_pkg::REG_IMAGE_COLS: cols_cfg_reg <= cfg_wr_data;
                sge_pkg::REG_IMAGE_ROWS: rows_cfg_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Saturate dimensions to the supported range
    always_comb begin
        priority if (CMP_W'(cols_cfg_reg) < CMP_W'(sge_pkg::MIN_DIM)) begin
            cols_eff = CMP_W'(sge_pkg::MIN_DIM);
        end else if (CMP_W'(cols_cfg_reg) > CMP_W'(MAX_COLS)) begin
            cols_eff = CMP_W'(MAX_COLS);
        end else begin
            cols_eff = CMP_W'(cols_cfg_reg);
        end
        priority if (rows_cfg_reg < sge_pkg::CFG_W'(sge_pkg::MIN_DIM)) begin
            rows_eff = sge_pkg::CFG_W'(sge_pkg::MIN_DIM);
        end else if (rows_cfg_reg > sge_pkg::CFG_W'(sge_pkg::MAX_ROWS)) begin
            rows_eff = sge_pkg::CFG_W'(sge_pkg::MAX_ROWS);
        end else begin
            rows_eff = rows_cfg_reg;
        end
    end

    // ---------------- handshake chain ----------------
    always_comb begin
        out_free = !m_valid_reg || m_tready;
        s2_fire  = s2_valid_reg && out_free;
        s2_free  = !s2_valid_reg || out_free;
        s1_fire  = s1_valid_reg && s2_free;
        s1_free  = !s1_valid_reg || s2_free;
        in_fire  = s_tvalid && s1_free;
    end

    assign s_tready = s1_free;

    // ---------------- raster position ----------------
    always_comb begin
        // frame_start restarts the raster before this pixel is placed
        cur_col   = s_tuser ? '0 : col_reg;
        cur_row   = s_tuser ? '0 : row_reg;
        col_plus  = CMP_W'(cur_col) + CMP_W'(1);
        row_plus  = sge_pkg::CFG_W'(cur_row) + sge_pkg::CFG_W'(1);
        row_end   = (col_plus >= cols_eff);
        frame_end = row_end && (row_plus >= rows_eff);
        in_tag.emit = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
        in_tag.last = frame_end;
        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : ROW_W'(row_plus);
        end else begin
            col_next = COL_W'(col_plus);
            row_next = cur_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage valids ----------------
    always_comb begin
        s1_valid_next = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_fire ? s1_tag_reg.emit : (s2_fire ? 1'b0 : s2_valid_reg);
        m_valid_next  = s2_fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_addr_reg  <= cur_col;
            s1_pixel_reg <= s_tdata[PW-1:0];
            s1_tag_reg   <= in_tag;
        end
        if (s1_fire) begin
            s2_last_reg <= s1_tag_reg.last;
        end
        if (s2_fire) begin
            m_last_reg <= s2_last_reg;
        end
    end

    // ---------------- line store ----------------
    // Upper byte: row two above; lower byte: row above. Write back shifts one row.
    assign wr_word = {mid_px, s1_pixel_reg};

    sge_line_mem #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_word),
        .rd_en   (in_fire),
        .rd_addr (cur_col),
        .rd_data (rd_word)
    );

    // A read issued in the same cycle as a write to the same column sees stale
    // data; capture the write-back word and substitute it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (in_fire) begin
            fwd_hit_reg <= s1_fire && (s1_addr_reg == cur_col);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            fwd_data_reg <= wr_word;
        end
    end

    always_comb begin
        line_word = fwd_hit_reg ? fwd_data_reg : rd_word;
        top_px    = line_word[sge_pkg::LINE_W-1:PW];
        mid_px    = line_word[PW-1:0];
    end

    // ---------------- window, gradients, energy ----------------
    sge_gradient u_gradient (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (s1_fire),
        .top     (top_px),
        .mid     (mid_px),
        .bot     (s1_pixel_reg),
        .gx      (gx),
        .gy      (gy)
    );

    sge_energy u_energy (
        .aclk      (aclk),
        .load      (s2_fire),
        .gx        (gx),
        .gy        (gy),
        .magnitude (magnitude)
    );

    // ---------------- result channel ----------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sge_pkg::TDATA_OUT_W'(magnitude);
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/sge_checker.sv
// Port-level checks for the Sobel gradient energy block, bound to the top level.
module sge_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sge_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic                            m_tlast
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result word holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // Energy never reaches the pad bit
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[sge_pkg::TDATA_OUT_W-1] == 1'b0))
        else $error("magnitude out of range");

    // Input backpressure only arises from a blocked result word
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without output stall");

endmodule

bind sobel_gradient_energy_top sge_checker u_sge_checker (.*);

FILE: dv/sobel_gradient_energy_top_test.sv
// Self-checking stream testbench for the 3x3 Sobel gradient energy block.
module sobel_gradient_energy_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT  = 40;    // stop printing mismatches past this many
    localparam int QUIET_LIMIT   = 2000;  // cycles without any word moving
    localparam int SETTLE_CYCLES = 8;     // pipeline is three stages deep
    localparam int RANDOM_PIXELS = 40;

    // One predicted result word
    typedef struct {
        logic [sge_pkg::MAG_W-1:0] magnitude;
        logic                      frame_last;
    } energy_word_t;

    logic                            aclk         = 1'b0;
    logic                            aresetn      = 1'b0;
    logic                            s_tvalid     = 1'b0;
    logic                            s_tready;
    logic [sge_pkg::TDATA_IN_W-1:0]  s_tdata      = '0;    // pixel
    logic                            s_tuser      = 1'b0;  // frame_start
    logic                            m_tvalid;
    logic                            m_tready     = 1'b0;
    logic [sge_pkg::TDATA_OUT_W-1:0] m_tdata;              // magnitude, zero pad
    logic                            m_tlast;              // frame_last
    logic                            cfg_wr_en    = 1'b0;
    logic [0:0]                      cfg_wr_index = sge_pkg::REG_IMAGE_COLS;
    logic [sge_pkg::CFG_W-1:0]       cfg_wr_data  = '0;

    sobel_gradient_energy_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // Predictor state: our own copy of the line stores, window, raster position
    // and the raw register values as last written.
    logic [sge_pkg::PIX_W-1:0] row_above     [sge_pkg::MAX_COLS];
    logic [sge_pkg::PIX_W-1:0] row_two_above [sge_pkg::MAX_COLS];
    logic [sge_pkg::PIX_W-1:0] win           [6];  // column c-2 top/mid/bottom, then c-1
    int unsigned               row_pos = 0;
    int unsigned               col_pos = 0;
    logic [sge_pkg::CFG_W-1:0] cols_reg = sge_pkg::CFG_RESET;
    logic [sge_pkg::CFG_W-1:0] rows_reg = sge_pkg::CFG_RESET;

    energy_word_t energy_due [$];   // results still owed by the block, oldest first

    int error_count   = 0;
    int pixels_sent   = 0;
    int send_gap_max  = 0;          // idle cycles the sender may insert per word
    int recv_gap_max  = 0;          // stall cycles the receiver may insert per word

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Out-of-range register values act as the nearest legal size.
    function automatic int unsigned clamp_dim(input logic [sge_pkg::CFG_W-1:0] raw,
                                              input int unsigned hi);
        if (raw < sge_pkg::MIN_DIM) return sge_pkg::MIN_DIM;
        if (raw > hi)               return hi;
        return raw;
    endfunction

    // Advance the predictor by one accepted pixel; queue a result when the
    // 3x3 window lies wholly inside the frame.
    function automatic void predict_gradient_energy(input logic [sge_pkg::PIX_W-1:0] px,
                                                    input logic frame_start);
        int unsigned  cols, rows, c, r, idx;
        int           top, mid, bot, tl, ml, bl, tm, bm, gx, gy, energy;
        logic         row_end, frame_end;
        energy_word_t w;
        cols = clamp_dim(cols_reg, sge_pkg::MAX_COLS);
        rows = clamp_dim(rows_reg, sge_pkg::MAX_ROWS);
        if (frame_start) begin
            row_pos = 0;
            col_pos = 0;
        end
        c   = col_pos;
        r   = row_pos;
        idx = (c < sge_pkg::MAX_COLS) ? c : sge_pkg::MAX_COLS - 1;
        top = row_two_above[idx];
        mid = row_above[idx];
        bot = px;
        row_end   = (c + 1 >= cols);
        frame_end = row_end && (r + 1 >= rows);
        if (r >= 2 && c >= 2) begin
            tl = win[0];
            ml = win[1];
            bl = win[2];
            tm = win[3];
            bm = win[5];
            gx = (top + 2 * mid + bot) - (tl + 2 * ml + bl);
            gy = (bl + 2 * bm + bot) - (tl + 2 * tm + top);
            energy = (gx * gx + gy * gy) >> sge_pkg::ENERGY_SHIFT;
            w.magnitude  = energy[sge_pkg::MAG_W-1:0];
            w.frame_last = frame_end;
            energy_due.push_back(w);
        end
        // slide the window one column right
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top[sge_pkg::PIX_W-1:0];
        win[4] = mid[sge_pkg::PIX_W-1:0];
        win[5] = px;
        row_two_above[idx] = mid[sge_pkg::PIX_W-1:0];
        row_above[idx]     = px;
        if (row_end) begin
            col_pos = 0;
            row_pos = frame_end ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic int pick_gap_max();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 17;
        endcase
    endfunction

    // Content styles: full range, hard black/white, and a narrow mid-gray band.
    function automatic logic [sge_pkg::PIX_W-1:0] draw_pixel(input int style);
        case (style)
            0:       return sge_pkg::PIX_W'($urandom_range(0, 255));
            1:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return sge_pkg::PIX_W'($urandom_range(100, 140));
        endcase
    endfunction

    // Offer one pixel word after a random gap and hold it until taken.
    // Predict at the accepting edge so the caller sees updated positions.
    task automatic send_pixel(input logic [sge_pkg::PIX_W-1:0] px, input logic frame_start);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= frame_start;
        do @(posedge aclk); while (!s_tready);
        predict_gradient_energy(px, frame_start);
        pixels_sent++;
    endtask

    // Drop valid and hold off until every owed result has come out, then let
    // the pipeline settle so border pixels still in flight are gone too.
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (energy_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; call only while the block is drained.
    task automatic write_reg(input sge_pkg::cfg_index_t idx,
                             input logic [sge_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        if (idx == sge_pkg::REG_IMAGE_COLS) cols_reg = val;
        else                                rows_reg = val;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    task automatic send_pixels(input int count, input logic frame_start, input int style);
        send_pixel(draw_pixel(style), frame_start);
        repeat (count - 1) send_pixel(draw_pixel(style), 1'b0);
    endtask

    // Feed pixels until the raster position wraps back to the frame origin;
    // now and then pause mid-frame until the result side has caught up.
    task automatic send_rest_of_frame(input int style);
        while (row_pos != 0 || col_pos != 0) begin
            if ($urandom_range(0, 99) == 0) wait_results_drained();
            send_pixel(draw_pixel(style), 1'b0);
        end
    endtask

    task automatic send_tile(input logic [sge_pkg::PIX_W-1:0] tile [9],
                             input logic frame_start);
        send_pixel(tile[0], frame_start);
        for (int i = 1; i < 9; i++) send_pixel(tile[i], 1'b0);
    endtask

    // Smallest 3x3 frames, one result per full frame: a vertical step at full swing,
    // a horizontal step entered without frame_start (relies on the wrap at
    // end of frame), an aborted frame restarted by frame_start, and a mixed
    // corner pattern under receiver stalls.
    task automatic test_smallest_frames();
        write_reg(sge_pkg::REG_IMAGE_COLS, 8'd3);
        write_reg(sge_pkg::REG_IMAGE_ROWS, 8'd3);
        send_gap_max = 0;
        recv_gap_max = 0;
        send_tile('{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255}, 1'b1);
        send_tile('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255}, 1'b0);
        send_gap_max = 17;
        send_pixels(4, 1'b1, 1);
        recv_gap_max = 17;
        send_tile('{8'd17, 8'd34, 8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd1, 8'd254},
                  1'b1);
        wait_results_drained();
    endtask

    // Register values outside 3..128 saturate: 0 acts as 3 and 255 as 128.
    // Run the tallest frame whole; cut the widest one short in its third row,
    // where a wrong row length already misaligns the window.
    task automatic test_clamped_sizes();
        send_gap_max = 3;
        recv_gap_max = 3;
        write_reg(sge_pkg::REG_IMAGE_COLS, 8'd0);
        write_reg(sge_pkg::REG_IMAGE_ROWS, 8'd255);
        send_pixel(draw_pixel(0), 1'b1);
        send_rest_of_frame(0);
        wait_results_drained();
        write_reg(sge_pkg::REG_IMAGE_COLS, 8'd255);
        write_reg(sge_pkg::REG_IMAGE_ROWS, 8'd0);
        send_pixels(int'(2 * sge_pkg::MAX_COLS + 5), 1'b1, 0);
        wait_results_drained();
    endtask

    // Change a size mid-frame: a position at or past the new bound wraps at
    // its next pixel. Only shrink the row length, so no row reaches columns
    // the rows above never wrote.
    task automatic test_size_change_mid_frame();
        send_gap_max = 17;
        recv_gap_max = 17;
        // narrower rows while sitting at column 5 of row 3
        write_reg(sge_pkg::REG_IMAGE_COLS, 8'd8);
        write_reg(sge_pkg::REG_IMAGE_ROWS, 8'd8);
        send_pixels(29, 1'b1, 0);
        wait_results_drained();
        write_reg(sge_pkg::REG_IMAGE_COLS, 8'd4);
        send_rest_of_frame(0);
        wait_results_drained();
        // fewer rows while already on row 5: frame ends with this row
        write_reg(sge_pkg::REG_IMAGE_COLS, 8'd6);
        write_reg(sge_pkg::REG_IMAGE_ROWS, 8'd10);
        send_pixels(30, 1'b1, 0);
        wait_results_drained();
        write_reg(sge_pkg::REG_IMAGE_ROWS, 8'd4);
        send_rest_of_frame(0);
        wait_results_drained();
        // more rows partway through row 1
        write_reg(sge_pkg::REG_IMAGE_COLS, 8'd5);
        write_reg(sge_pkg::REG_IMAGE_ROWS, 8'd3);
        send_pixels(7, 1'b1, 0);
        wait_results_drained();
        write_reg(sge_pkg::REG_IMAGE_ROWS, 8'd6);
        send_rest_of_frame(0);
        wait_results_drained();
    endtask

    // Mostly whole frames of random small sizes and content, with some frames
    // cut short and some bursts of pixels carrying random frame_start.
    // Sizes change only at a frame origin, so rows two and up always find
    // their columns written by the rows above.
    task automatic test_random_traffic();
        int start_count, kind, style, frame_pixels;
        logic frame_start;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS) begin
            send_gap_max = pick_gap_max();
            recv_gap_max = pick_gap_max();
            if (row_pos == 0 && col_pos == 0 && $urandom_range(0, 2) == 0) begin
                wait_results_drained();
                if ($urandom_range(0, 3) != 0)
                    write_reg(sge_pkg::REG_IMAGE_COLS,
                              sge_pkg::CFG_W'($urandom_range(0, 14)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(sge_pkg::REG_IMAGE_ROWS,
                              sge_pkg::CFG_W'($urandom_range(0, 12)));
            end
            kind  = $urandom_range(0, 19);
            style = $urandom_range(0, 2);
            frame_start = (row_pos != 0 || col_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
            frame_pixels = clamp_dim(cols_reg, sge_pkg::MAX_COLS) *
                           clamp_dim(rows_reg, sge_pkg::MAX_ROWS);
            if (kind < 16) begin
                send_pixel(draw_pixel(style), frame_start);
                send_rest_of_frame(style);
            end else if (kind < 18) begin
                send_pixels($urandom_range(1, frame_pixels - 1), frame_start, style);
            end else begin
                repeat ($urandom_range(1, 12))
                    send_pixel(draw_pixel(style), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Result side: stall a random number of cycles after each accepted word.
    initial begin : drive_result_ready
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) hold = $urandom_range(0, recv_gap_max);
            @(negedge aclk);
            if (hold != 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result word with the oldest owed one.
    always @(posedge aclk) begin : check_results
        energy_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (energy_due.size() == 0) begin
                if (error_count < REPORT_LIMIT)
                    $display("%0t: unexpected result: expected none, actual magnitude %0d last %0b",
                             $time, m_tdata[sge_pkg::MAG_W-1:0], m_tlast);
                error_count++;
            end else begin
                want = energy_due.pop_front();
                if (m_tdata[sge_pkg::MAG_W-1:0] !== want.magnitude) begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: magnitude mismatch: expected %0d, actual %0d",
                                 $time, want.magnitude, m_tdata[sge_pkg::MAG_W-1:0]);
                    error_count++;
                end
                if (m_tlast !== want.frame_last) begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                                 $time, want.frame_last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Hang detector: end the run if no word moves on either side for too long.
    always @(posedge aclk) begin : watchdog
        int quiet_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("sobel_gradient_energy_top_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < sge_pkg::MAX_COLS; i++) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
        end
        for (int i = 0; i < 6; i++) win[i] = '0;
        // hold reset, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_smallest_frames();
        test_clamped_sizes();
        test_size_change_mid_frame();
        test_random_traffic();

        wait_results_drained();
        // leave room for any stray extra result to show up
        repeat (16) @(posedge aclk);
        if (error_count == 0)
            $display("sobel_gradient_energy_top_test: PASS");
        else
            $display("sobel_gradient_energy_top_test: FAIL");
        $finish;
    end

endmodule
